FILE: rtl/apdbm_pkg.sv
// ----------------------------------------------------------------------------
// apdbm_pkg
// Shared types and constants of the auto-ranging peak-decay bar meter.
// ----------------------------------------------------------------------------
`default_nettype none

package apdbm_pkg;

    localparam int PEAK_W     = 32;
    localparam int PCT_W      = 15;
    localparam int WEIGHT_W   = 8;
    localparam int DECAY_W    = 16;
    localparam int PIXEL_W    = 5;
    localparam int DVD_W      = PEAK_W + PCT_W;
    localparam int QUOT_W     = 16;
    localparam int DSH_W      = PEAK_W + QUOT_W;
    localparam int CNT_W      = $clog2(QUOT_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 8'd3;
    localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd0;

    localparam logic [PCT_W-1:0] FULL_SCALE = 15'd25600;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SH for x below 2**15
    localparam int               RECIP_W   = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int               RECIP_SH  = 19;
    localparam int               Q8_SH     = 8;

    localparam int BAR_PIXELS_DEF = 20;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [PEAK_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [PCT_W-1:0]   quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/autorange_peak_decay_bar_meter_core.sv
// ----------------------------------------------------------------------------
// autorange_peak_decay_bar_meter_core
// Auto-ranging peak meter with decay, smoothed level and bar pixel outputs.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one 32-bit throughput sample per item.
// Output channel: o_valid / i_ready carry cover height, marker row, level
// percent (Q7.8, saturated at 100) and the updated peak.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0: smoothing weight, 1: decay step); other indexes are ignored.
// Write registers only while no item is in flight.
// The core accepts a new sample only once the last one has passed to the
// output register. Both divisions (sample over peak, skipped when the peak
// is zero, and weighted average over weight plus one) run on one shared
// restoring divider at one quotient bit per cycle. The pixel scaling takes
// two registered multiply steps.
// The result sits in an output register; while the receiver stalls the core
// finishes the next item and then holds it until the register frees up.
// Reset clears peak and average to zero, weight to 3 and decay to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module autorange_peak_decay_bar_meter_core #(
    parameter int BAR_PIXELS = apdbm_pkg::BAR_PIXELS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [apdbm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [apdbm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [apdbm_pkg::PEAK_W-1:0]        i_sample,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [apdbm_pkg::PIXEL_W-1:0]            o_cover_height,
    output logic [apdbm_pkg::PIXEL_W-1:0]            o_marker_row,
    output logic [apdbm_pkg::PCT_W-1:0]              o_level_percent,
    output logic [apdbm_pkg::PEAK_W-1:0]             o_range_peak
);
    import apdbm_pkg::*;

    localparam int BP_W   = $clog2(BAR_PIXELS + 1);
    localparam int PROD_W = PCT_W + BP_W;
    localparam int SCL_W  = PROD_W - Q8_SH;
    localparam int RPR_W  = SCL_W + RECIP_W;
    localparam int PIX_W  = RPR_W - RECIP_SH;
    localparam int SUM_W  = PCT_W + WEIGHT_W + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PEAK    = 3'd1;
    localparam logic [2:0] S_DIV_PCT = 3'd2;
    localparam logic [2:0] S_AVG     = 3'd3;
    localparam logic [2:0] S_DIV_AVG = 3'd4;
    localparam logic [2:0] S_PIX_A   = 3'd5;
    localparam logic [2:0] S_PIX_B   = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [WEIGHT_W-1:0]   r_weight;
    logic [DECAY_W-1:0]    r_decay;
    logic [PEAK_W-1:0]     r_peak;
    logic [PCT_W-1:0]      r_smooth;
    logic [PEAK_W-1:0]     r_sample;
    logic [PCT_W-1:0]      r_pct;
    logic [PROD_W-1:0]     r_prod_avg;
    logic [PROD_W-1:0]     r_prod_pct;
    logic [RPR_W-1:0]      r_rpr_avg;
    logic [RPR_W-1:0]      r_rpr_pct;
    logic                  r_out_valid;
    logic [PIXEL_W-1:0]    r_cover;
    logic [PIXEL_W-1:0]    r_row;
    logic [PCT_W-1:0]      r_out_pct;
    logic [PEAK_W-1:0]     r_out_peak;

    logic [PEAK_W-1:0]     peak_max;
    logic [PEAK_W-1:0]     peak_new;
    logic [SUM_W-1:0]      avg_sum;
    logic [PIX_W-1:0]      pix_avg;
    logic [PIX_W-1:0]      pix_pct;
    logic [8:0]            cover_full;
    logic [8:0]            row_full;
    logic                  out_free;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    apdbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign peak_max = (r_peak < r_sample) ? r_sample : r_peak;
    assign peak_new = (r_decay != '0 && PEAK_W'(r_decay) < peak_max)
                    ? peak_max - PEAK_W'(r_decay) : peak_max;
    assign avg_sum  = SUM_W'(r_smooth) * SUM_W'(r_weight) + SUM_W'(r_pct);

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(r_sample) * DVD_W'(FULL_SCALE);
        div_req.divisor  = peak_new;
        if (r_state == S_PEAK) begin
            div_req.start = (peak_new != '0);
        end else if (r_state == S_AVG) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(avg_sum);
            div_req.divisor  = PEAK_W'(r_weight) + PEAK_W'(1);
        end
    end

    assign pix_avg    = r_rpr_avg[RPR_W-1:RECIP_SH];
    assign pix_pct    = r_rpr_pct[RPR_W-1:RECIP_SH];
    assign cover_full = 9'(BAR_PIXELS + 1) - 9'(pix_avg);
    assign row_full   = 9'(BAR_PIXELS + 3) - 9'(pix_pct);
    assign out_free   = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_PEAK;
            S_PEAK:    n_state = (peak_new != '0) ? S_DIV_PCT : S_AVG;
            S_DIV_PCT: if (div_rsp.done) n_state = S_AVG;
            S_AVG:     n_state = S_DIV_AVG;
            S_DIV_AVG: if (div_rsp.done) n_state = S_PIX_A;
            S_PIX_A:   n_state = S_PIX_B;
            S_PIX_B:   n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_weight    <= WEIGHT_RST;
            r_decay     <= DECAY_RST;
            r_peak      <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SMOOTHING: r_weight <= i_cfg_wdata[WEIGHT_W-1:0];
                    CFG_DECAY:     r_decay  <= i_cfg_wdata[DECAY_W-1:0];
                    default:       ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample;
                    end
                end
                S_PEAK: begin
                    r_peak <= peak_new;
                    r_pct  <= '0;
                end
                S_DIV_PCT: begin
                    if (div_rsp.done) begin
                        r_pct <= div_rsp.quot;
                    end
                end
                S_DIV_AVG: begin
                    if (div_rsp.done) begin
                        r_smooth <= div_rsp.quot;
                    end
                end
                S_PIX_A: begin
                    r_prod_avg <= PROD_W'(r_smooth) * PROD_W'(BAR_PIXELS);
                    r_prod_pct <= PROD_W'(r_pct) * PROD_W'(BAR_PIXELS);
                end
                S_PIX_B: begin
                    r_rpr_avg <= RPR_W'(r_prod_avg[PROD_W-1:Q8_SH]) * RPR_W'(RECIP_100);
                    r_rpr_pct <= RPR_W'(r_prod_pct[PROD_W-1:Q8_SH]) * RPR_W'(RECIP_100);
                end
                S_OUT: begin
                    if (out_free) begin
                        r_cover     <= cover_full[PIXEL_W-1:0];
                        r_row       <= row_full[PIXEL_W-1:0];
                        r_out_pct   <= r_pct;
                        r_out_peak  <= r_peak;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_cover_height  = r_cover;
    assign o_marker_row    = r_row;
    assign o_level_percent = r_out_pct;
    assign o_range_peak    = r_out_peak;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while core idle");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_PCT || r_state == S_DIV_AVG))
        else $error("divider finished outside a divide state");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smooth <= FULL_SCALE)
        else $error("smoothed level above full scale");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_percent <= FULL_SCALE))
        else $error("level percent above full scale");

endmodule

`default_nettype wire

FILE: rtl/apdbm_div.sv
// ----------------------------------------------------------------------------
// apdbm_div
// Shared restoring divider, one quotient bit per cycle, saturated at full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module apdbm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire apdbm_pkg::t_div_req i_req,
    output apdbm_pkg::t_div_rsp    o_rsp
);
    import apdbm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_quot;

    logic              ge;
    logic [DSH_W-1:0]  diff;

    assign ge   = {1'b0, r_rem} >= r_dsh;
    assign diff = {1'b0, r_rem} - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W);
                r_rem  <= i_req.dividend;
                r_dsh  <= {i_req.divisor, QUOT_W'(0)};
                r_quot <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(QUOT_W)) begin
                    r_ovf <= ge;
                end else begin
                    r_quot <= {r_quot[QUOT_W-2:0], ge};
                    if (ge) begin
                        r_rem <= diff[DVD_W-1:0];
                    end
                end
                r_dsh <= r_dsh >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_ovf || r_quot > QUOT_W'(FULL_SCALE)) ? FULL_SCALE
                                                                : r_quot[PCT_W-1:0];

endmodule

`default_nettype wire
